### hdl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Types, constants and the reciprocal table shared by the 3x3 box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

	localparam int PIX_W      = 8;
	localparam int CFG_W      = 12;
	localparam int CFG_IDX_W  = 4;
	localparam int ROW_W      = 12;
	localparam int ROW_IN_W   = 13;
	localparam int WIDTH_RST  = 640;
	localparam int HEIGHT_RST = 480;
	localparam int SUM_W      = 12;
	localparam int CNT_W      = 4;
	localparam int RECIP_W    = 17;
	localparam int RECIP_SH   = 16;
	localparam int PROD_W     = SUM_W + RECIP_W;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} rgb_t;

	// one window column: top is the row above the output pixel
	typedef struct packed {
		rgb_t top;
		rgb_t mid;
		rgb_t bot;
	} col_t;

	typedef struct packed {
		logic emit;
		logic frame_end;
		logic top;
		logic bottom;
		logic left;
		logic right;
	} tag_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic             frame_end;
	} result_t;

	// ceil(2^16 / n); exact for every sum up to 9 * 255
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
		logic [RECIP_W-1:0] m;
		case (cnt)
			4'd1:    m = 17'd65536;
			4'd2:    m = 17'd32768;
			4'd3:    m = 17'd21846;
			4'd4:    m = 17'd16384;
			4'd6:    m = 17'd10923;
			4'd9:    m = 17'd7282;
			default: m = 17'd65536;
		endcase
		return m;
	endfunction

endpackage

### hdl/bb3_if.sv
// ----------------------------------------------------------------------------
// bb3 interfaces
// Pixel, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bb3_pix_if;
	logic                       valid;
	logic                       ready;
	logic [bb3_pkg::PIX_W-1:0] red_in;
	logic [bb3_pkg::PIX_W-1:0] green_in;
	logic [bb3_pkg::PIX_W-1:0] blue_in;
	logic                       drain;

	modport source (output valid, red_in, green_in, blue_in, drain, input ready);
	modport sink (input valid, red_in, green_in, blue_in, drain, output ready);
endinterface

interface bb3_res_if;
	logic                       valid;
	logic                       ready;
	logic [bb3_pkg::PIX_W-1:0] red_out;
	logic [bb3_pkg::PIX_W-1:0] green_out;
	logic [bb3_pkg::PIX_W-1:0] blue_out;
	logic                       frame_end;

	modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
	modport sink (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

interface bb3_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bb3_pkg::CFG_IDX_W-1:0] index;
	logic [bb3_pkg::CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hdl/bb3_ctrl.sv
// ----------------------------------------------------------------------------
// bb3_ctrl
// Frame registers and position bookkeeping for each accepted word.
// ----------------------------------------------------------------------------
module bb3_ctrl #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bb3_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           fire,
	input  logic                           drain,
	output logic                           eff,
	output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] col,
	output bb3_pkg::tag_t                  tag
);
	import bb3_pkg::*;

	localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int W_RST  = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

	logic [ADDR_W-1:0]   w_last_q;
	logic [ROW_W-1:0]    h_last_q;
	logic [ADDR_W-1:0]   col_in_q;
	logic [ROW_IN_W-1:0] row_in_q;
	logic [ADDR_W-1:0]   col_o_q;
	logic [ROW_W-1:0]    row_o_q;
	logic                emit_q;
	logic [ADDR_W-1:0]   w_cfg_last;
	logic [ROW_W-1:0]    h_cfg_last;
	logic                pixel_phase;
	logic                cfg_hit;

	always_comb begin
		if (cfg_data == '0) begin
			w_cfg_last = '0;
		end else if (int'(cfg_data) > MAX_WIDTH) begin
			w_cfg_last = ADDR_W'(MAX_WIDTH - 1);
		end else begin
			w_cfg_last = ADDR_W'(cfg_data - 1'b1);
		end
		h_cfg_last = (cfg_data == '0) ? '0 : ROW_W'(cfg_data - 1'b1);
	end

	assign cfg_hit = cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

	// drain words that arrive before the last pixel are dropped
	assign pixel_phase = row_in_q <= {1'b0, h_last_q};
	assign eff         = fire && !(drain && pixel_phase);
	assign col         = col_in_q;

	always_comb begin
		tag.emit      = emit_q;
		tag.top       = row_o_q != '0;
		tag.bottom    = row_o_q != h_last_q;
		tag.left      = col_o_q != '0;
		tag.right     = col_o_q != w_last_q;
		tag.frame_end = emit_q && (row_o_q == h_last_q) && (col_o_q == w_last_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= ADDR_W'(W_RST - 1);
			h_last_q <= ROW_W'(HEIGHT_RST - 1);
			col_in_q <= '0;
			row_in_q <= '0;
			col_o_q  <= '0;
			row_o_q  <= '0;
			emit_q   <= 1'b0;
		end else if (cfg_hit) begin
			if (cfg_index == REG_FRAME_WIDTH) begin
				w_last_q <= w_cfg_last;
			end else begin
				h_last_q <= h_cfg_last;
			end
			col_in_q <= '0;
			row_in_q <= '0;
			col_o_q  <= '0;
			row_o_q  <= '0;
			emit_q   <= 1'b0;
		end else if (eff) begin
			if (tag.frame_end) begin
				col_in_q <= '0;
				row_in_q <= '0;
				col_o_q  <= '0;
				row_o_q  <= '0;
				emit_q   <= 1'b0;
			end else begin
				if (col_in_q == w_last_q) begin
					col_in_q <= '0;
					row_in_q <= row_in_q + 1'b1;
				end else begin
					col_in_q <= col_in_q + 1'b1;
				end
				// results start one row and one pixel behind the input
				if (row_in_q == ROW_IN_W'(1) && col_in_q == '0) begin
					emit_q <= 1'b1;
				end
				if (emit_q) begin
					if (!tag.right) begin
						col_o_q <= '0;
						row_o_q <= row_o_q + 1'b1;
					end else begin
						col_o_q <= col_o_q + 1'b1;
					end
				end
			end
		end
	end

endmodule

### hdl/bb3_line.sv
// ----------------------------------------------------------------------------
// bb3_line
// Two line stores and the 3x3 window shift register.
// ----------------------------------------------------------------------------
module bb3_line #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                eff,
	input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] col,
	input  bb3_pkg::rgb_t       pix,
	input  bb3_pkg::tag_t       tag,
	output bb3_pkg::col_t [2:0] win,
	output bb3_pkg::tag_t       tag_out
);
	import bb3_pkg::*;

	localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	rgb_t              line_up1_q [MAX_WIDTH];
	rgb_t              line_up2_q [MAX_WIDTH];
	rgb_t              rd_up1_s1;
	rgb_t              rd_up2_s1;
	logic              v_s1;
	logic              fwd_s1;
	tag_t              tag_s1;
	rgb_t              pix_s1;
	logic [ADDR_W-1:0] addr_s1;
	tag_t              tag_s2;
	rgb_t              pix_s2;
	rgb_t              up1_s2;
	col_t [2:0]        win_q;
	tag_t              tag_in;
	rgb_t              up1;
	rgb_t              up2;

	always_comb begin
		tag_in      = tag;
		tag_in.emit = eff && tag.emit;
	end

	// one-pixel rows: the read misses the write of the word just ahead
	assign up1 = fwd_s1 ? pix_s2 : rd_up1_s1;
	assign up2 = fwd_s1 ? up1_s2 : rd_up2_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_up1_s1 <= line_up1_q[col];
			rd_up2_s1 <= line_up2_q[col];
			if (v_s1) begin
				line_up1_q[addr_s1] <= pix_s1;
				line_up2_q[addr_s1] <= up1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else if (adv) begin
			v_s1   <= eff;
			fwd_s1 <= eff && v_s1 && (col == addr_s1);
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1  <= pix;
			addr_s1 <= col;
			pix_s2  <= pix_s1;
			up1_s2  <= up1;
			if (v_s1) begin
				win_q[0]     <= win_q[1];
				win_q[1]     <= win_q[2];
				win_q[2].top <= up2;
				win_q[2].mid <= up1;
				win_q[2].bot <= pix_s1;
			end
		end
	end

	assign win     = win_q;
	assign tag_out = tag_s2;

endmodule

### hdl/bb3_avg.sv
// ----------------------------------------------------------------------------
// bb3_avg
// Masked window sums, then division by the neighbor count via reciprocal.
// ----------------------------------------------------------------------------
module bb3_avg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  bb3_pkg::col_t [2:0] win,
	input  bb3_pkg::tag_t       tag,
	output logic                valid,
	output bb3_pkg::result_t    res
);
	import bb3_pkg::*;

	logic [SUM_W-1:0]   col_r [3];
	logic [SUM_W-1:0]   col_g [3];
	logic [SUM_W-1:0]   col_b [3];
	logic [SUM_W-1:0]   sum_r;
	logic [SUM_W-1:0]   sum_g;
	logic [SUM_W-1:0]   sum_b;
	logic [1:0]         nrow;
	logic [1:0]         ncol;
	logic [CNT_W-1:0]   cnt;
	logic               v_s3;
	logic               fe_s3;
	logic [SUM_W-1:0]   sum_r_s3;
	logic [SUM_W-1:0]   sum_g_s3;
	logic [SUM_W-1:0]   sum_b_s3;
	logic [RECIP_W-1:0] recip_s3;
	logic [PROD_W-1:0]  prod_r;
	logic [PROD_W-1:0]  prod_g;
	logic [PROD_W-1:0]  prod_b;

	function automatic logic [SUM_W-1:0] tri_sum(
		input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b,
		input logic [SUM_W-1:0] c,
		input logic             use_a,
		input logic             use_c
	);
		return (use_a ? a : '0) + b + (use_c ? c : '0);
	endfunction

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			col_r[j] = tri_sum(SUM_W'(win[j].top.red), SUM_W'(win[j].mid.red),
				SUM_W'(win[j].bot.red), tag.top, tag.bottom);
			col_g[j] = tri_sum(SUM_W'(win[j].top.green), SUM_W'(win[j].mid.green),
				SUM_W'(win[j].bot.green), tag.top, tag.bottom);
			col_b[j] = tri_sum(SUM_W'(win[j].top.blue), SUM_W'(win[j].mid.blue),
				SUM_W'(win[j].bot.blue), tag.top, tag.bottom);
		end
		sum_r = tri_sum(col_r[0], col_r[1], col_r[2], tag.left, tag.right);
		sum_g = tri_sum(col_g[0], col_g[1], col_g[2], tag.left, tag.right);
		sum_b = tri_sum(col_b[0], col_b[1], col_b[2], tag.left, tag.right);
		nrow  = 2'd1 + {1'b0, tag.top} + {1'b0, tag.bottom};
		ncol  = 2'd1 + {1'b0, tag.left} + {1'b0, tag.right};
		cnt   = {2'b00, nrow} * {2'b00, ncol};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= tag.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fe_s3    <= tag.frame_end;
			sum_r_s3 <= sum_r;
			sum_g_s3 <= sum_g;
			sum_b_s3 <= sum_b;
			recip_s3 <= recip(cnt);
		end
	end

	assign prod_r = PROD_W'(sum_r_s3) * PROD_W'(recip_s3);
	assign prod_g = PROD_W'(sum_g_s3) * PROD_W'(recip_s3);
	assign prod_b = PROD_W'(sum_b_s3) * PROD_W'(recip_s3);

	always_comb begin
		res.red       = prod_r[RECIP_SH +: PIX_W];
		res.green     = prod_g[RECIP_SH +: PIX_W];
		res.blue      = prod_b[RECIP_SH +: PIX_W];
		res.frame_end = fe_s3;
	end

	assign valid = v_s3;

endmodule

### hdl/bb3_obuf.sv
// ----------------------------------------------------------------------------
// bb3_obuf
// Two-word output buffer; keeps the pipeline moving while a result waits.
// ----------------------------------------------------------------------------
module bb3_obuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bb3_pkg::result_t din,
	output logic             room,
	output logic             valid,
	output bb3_pkg::result_t dout,
	input  logic             ready
);
	import bb3_pkg::*;

	result_t    buf_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop   = valid && ready;
	assign room  = cnt_q != 2'd2;
	assign valid = cnt_q != 2'd0;
	assign dout  = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hdl/box_blur_3x3_rgb_unit.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_unit
// 3x3 box blur over an RGB raster stream. Each pixel becomes, per channel,
// the truncated mean of its in-frame neighbors (divisor 9, 6, 4, or 3, 2, 1
// for one-pixel-wide or one-row frames). One word is taken per clock while
// the buffer has room; the result for pixel k is computed when word k+W+1
// is accepted, then registered. After the last pixel of a frame send W+1
// drain words to flush the last row; frame_end marks the last result, and
// the next word starts a new frame. Drain words sent before a frame is
// complete are dropped, and pixels sent after it act as drain words. The
// two line stores are MAX_WIDTH x 24 single-port-write memories; width
// above MAX_WIDTH saturates, width or height 0 counts as 1. A write to
// either register restarts the frame; write only while the unit is idle.
// Input ready drops only when the two-word output buffer is full.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_unit #(
	parameter int MAX_WIDTH = 2048
) (
	input logic       clk,
	input logic       arst_n,
	bb3_cfg_if.sink   cfg,
	bb3_pix_if.sink   pixel,
	bb3_res_if.source result
);
	import bb3_pkg::*;

	localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic              adv;
	logic              fire;
	logic              eff;
	logic [ADDR_W-1:0] col;
	tag_t              tag_s0;
	tag_t              tag_s2;
	rgb_t              pix_s0;
	col_t [2:0]        win;
	logic              res_valid;
	result_t           res_s3;
	result_t           res_out;

	assign cfg.ready   = 1'b1;
	assign pixel.ready = adv;
	assign fire        = pixel.valid && adv;

	always_comb begin
		pix_s0.red   = pixel.red_in;
		pix_s0.green = pixel.green_in;
		pix_s0.blue  = pixel.blue_in;
	end

	bb3_ctrl #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg.valid),
		.cfg_index(cfg.index),
		.cfg_data (cfg.data),
		.fire     (fire),
		.drain    (pixel.drain),
		.eff      (eff),
		.col      (col),
		.tag      (tag_s0)
	);

	bb3_line #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.eff    (eff),
		.col    (col),
		.pix    (pix_s0),
		.tag    (tag_s0),
		.win    (win),
		.tag_out(tag_s2)
	);

	bb3_avg u_avg (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.win   (win),
		.tag   (tag_s2),
		.valid (res_valid),
		.res   (res_s3)
	);

	bb3_obuf u_obuf (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (adv && res_valid),
		.din   (res_s3),
		.room  (adv),
		.valid (result.valid),
		.dout  (res_out),
		.ready (result.ready)
	);

	assign result.red_out   = res_out.red;
	assign result.green_out = res_out.green;
	assign result.blue_out  = res_out.blue;
	assign result.frame_end = res_out.frame_end;

endmodule

### tb/bb3_blur_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bb3_blur_check
// Watches the configuration, pixel and result channels of the 3x3 box blur,
// keeps its own copy of the frame position and of the pixels taken so far,
// computes the blurred word due for every accepted pixel or drain word and
// compares each accepted result word field by field with the oldest one.
// ----------------------------------------------------------------------------
module bb3_blur_check #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic clk,
	input  logic arst_n,
	bb3_cfg_if   cfg,
	bb3_pix_if   pixel,
	bb3_res_if   result,
	output int   errors,
	output int   pending
);

	import bb3_pkg::*;

	// two rows plus a window's worth, indexed by position in the frame
	localparam int STORE_DEPTH = 2 * MAX_WIDTH + 3;

	rgb_t             frame_pix [STORE_DEPTH];
	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;
	int               col_pos;
	int               row_pos;
	int               drains_taken;
	result_t          blurred_q [$];

	function automatic int active_width();
		if (width_reg == '0)
			return 1;
		if (int'(width_reg) > MAX_WIDTH)
			return MAX_WIDTH;
		return int'(width_reg);
	endfunction

	function automatic int active_height();
		return (height_reg == '0) ? 1 : int'(height_reg);
	endfunction

	function automatic void restart_frame();
		col_pos      = 0;
		row_pos      = 0;
		drains_taken = 0;
		blurred_q.delete();
	endfunction

	task automatic blur_word(input rgb_t px, input logic is_drain);
		int      w, h, total, taken, t, k, r, c, rr, cc, cnt;
		int      sum_r, sum_g, sum_b;
		rgb_t    nb;
		result_t res;
		w     = active_width();
		h     = active_height();
		total = w * h;
		taken = row_pos * w + col_pos;
		if (taken < total) begin
			// drain words inside a frame are dropped
			if (is_drain)
				return;
			frame_pix[taken % STORE_DEPTH] = px;
			t = taken;
			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
			end
		end else begin
			// past the last pixel every word flushes, pixel or not
			t = total + drains_taken;
			drains_taken++;
		end
		if (t < w + 1)
			return;
		k     = t - (w + 1);
		r     = k / w;
		c     = k % w;
		cnt   = 0;
		sum_r = 0;
		sum_g = 0;
		sum_b = 0;
		for (rr = r - 1; rr <= r + 1; rr++) begin
			for (cc = c - 1; cc <= c + 1; cc++) begin
				if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
					nb     = frame_pix[(rr * w + cc) % STORE_DEPTH];
					sum_r += nb.red;
					sum_g += nb.green;
					sum_b += nb.blue;
					cnt++;
				end
			end
		end
		res.red       = PIX_W'(sum_r / cnt);
		res.green     = PIX_W'(sum_g / cnt);
		res.blue      = PIX_W'(sum_b / cnt);
		res.frame_end = (k + 1 >= total);
		if (res.frame_end) begin
			col_pos      = 0;
			row_pos      = 0;
			drains_taken = 0;
		end
		blurred_q.push_back(res);
	endtask

	task automatic check_field(input string fname, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
		end
	endtask

	task automatic check_result();
		result_t want;
		if (blurred_q.size() == 0) begin
			errors++;
			$display("%0t: result word with none expected, got r %0d g %0d b %0d end %0b",
				$time, result.red_out, result.green_out, result.blue_out, result.frame_end);
			return;
		end
		want = blurred_q.pop_front();
		check_field("red_out", want.red, result.red_out);
		check_field("green_out", want.green, result.green_out);
		check_field("blue_out", want.blue, result.blue_out);
		check_field("frame_end", want.frame_end, result.frame_end);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg  = CFG_W'(WIDTH_RST);
			height_reg = CFG_W'(HEIGHT_RST);
			errors     = 0;
			restart_frame();
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_FRAME_WIDTH) begin
					width_reg = cfg.data;
					restart_frame();
				end else if (cfg.index == REG_FRAME_HEIGHT) begin
					height_reg = cfg.data;
					restart_frame();
				end
			end
			if (result.valid && result.ready)
				check_result();
			if (pixel.valid && pixel.ready)
				blur_word('{blue: pixel.blue_in, green: pixel.green_in, red: pixel.red_in},
					pixel.drain);
		end
		pending = blurred_q.size();
	end

endmodule

### tb/tb_box_blur_3x3_rgb_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_rgb_unit
// Stimulus for the 3x3 box blur: directed frames for corners, edges, thin
// frames, size clamping and restarts, then random frames under three idling
// patterns with stray drain and pixel words and one long result stall. The
// checker beside the block predicts and compares every result word; this
// module gives the verdict.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_rgb_unit;

	import bb3_pkg::*;

	localparam int                   MAX_W         = 2048;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE     = CFG_IDX_W'(15);
	localparam int                   RUN_LIMIT     = 500000;
	localparam int                   SETTLE_CYCLES = 16;
	localparam int                   HOLD_CYCLES   = 300;
	localparam int                   MODE_ITEMS    = 350;

	logic             clk;
	logic             arst_n;
	int               errors;
	int               pending;
	int               cycles = 0;
	int               src_idle_pct = 0;
	int               snk_idle_pct = 0;
	int               words_sent = 0;
	bit               long_hold_req = 1'b0;
	bit               long_hold_done = 1'b0;
	logic [CFG_W-1:0] width_val = CFG_W'(WIDTH_RST);
	logic [CFG_W-1:0] height_val = CFG_W'(HEIGHT_RST);

	bb3_cfg_if cfg ();
	bb3_pix_if pixel ();
	bb3_res_if result ();

	box_blur_3x3_rgb_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.pixel  (pixel),
		.result (result)
	);

	bb3_blur_check #(
		.MAX_WIDTH (MAX_W)
	) u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.pixel   (pixel),
		.result  (result),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("tb_box_blur_3x3_rgb_unit: done, errors");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off to fill the block
	initial begin
		int n;
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req && !long_hold_done) begin
				result.ready <= 1'b0;
				for (n = 0; n < HOLD_CYCLES; n++)
					@(negedge clk);
				long_hold_done = 1'b1;
			end
			result.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	function automatic int frame_cols();
		if (width_val == '0)
			return 1;
		if (int'(width_val) > MAX_W)
			return MAX_W;
		return int'(width_val);
	endfunction

	function automatic int frame_rows();
		return (height_val == '0) ? 1 : int'(height_val);
	endfunction

	// bias toward the channel extremes
	function automatic logic [PIX_W-1:0] chan_value();
		if ($urandom_range(3) == 0)
			return $urandom_range(1) ? 8'hFF : 8'h00;
		return PIX_W'($urandom_range(255));
	endfunction

	task automatic send_word(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
		input logic [PIX_W-1:0] b, input logic is_drain);
		while ($urandom_range(99) < src_idle_pct) begin
			pixel.valid <= 1'b0;
			@(negedge clk);
		end
		pixel.valid    <= 1'b1;
		pixel.red_in   <= r;
		pixel.green_in <= g;
		pixel.blue_in  <= b;
		pixel.drain    <= is_drain;
		do
			@(posedge clk);
		while (!pixel.ready);
		@(negedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do
			@(posedge clk);
		while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
		@(negedge clk);
		if (idx == REG_FRAME_WIDTH)
			width_val = val;
		else if (idx == REG_FRAME_HEIGHT)
			height_val = val;
	endtask

	// drop valid, wait out all results, then let the pipeline empty
	task automatic settle();
		pixel.valid <= 1'b0;
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic send_pixels(input int n, input bit noisy);
		int i;
		for (i = 0; i < n; i++) begin
			if (noisy && $urandom_range(19) == 0)
				send_word(chan_value(), chan_value(), chan_value(), 1'b1);
			send_word(chan_value(), chan_value(), chan_value(), 1'b0);
			words_sent++;
		end
	endtask

	// a pixel word after the frame is complete counts as a drain
	task automatic send_drains(input int n, input bit noisy);
		int i;
		for (i = 0; i < n; i++) begin
			send_word(chan_value(), chan_value(), chan_value(),
				!(noisy && $urandom_range(9) == 0));
			words_sent++;
		end
	endtask

	task automatic send_frame(input bit noisy);
		send_pixels(frame_cols() * frame_rows(), noisy);
		send_drains(frame_cols() + 1, noisy);
	endtask

	task automatic pick_geometry();
		int          sel;
		logic [11:0] w;
		logic [11:0] h;
		sel = $urandom_range(99);
		if (sel < 4)
			w = '0;
		else if (sel < 84)
			w = 12'($urandom_range(1, 8));
		else
			w = 12'($urandom_range(9, 40));
		sel = $urandom_range(99);
		if (sel < 4)
			h = '0;
		else if (sel < 80 || w > 12'd8)
			h = 12'($urandom_range(1, 6));
		else
			h = 12'($urandom_range(7, 20));
		case ($urandom_range(7))
			0: set_reg(REG_FRAME_WIDTH, w);
			1: set_reg(REG_FRAME_HEIGHT, h);
			2, 3: begin
				set_reg(REG_FRAME_HEIGHT, h);
				set_reg(REG_FRAME_WIDTH, w);
			end
			default: begin
				set_reg(REG_FRAME_WIDTH, w);
				set_reg(REG_FRAME_HEIGHT, h);
			end
		endcase
	endtask

	initial begin
		int mode;
		int i;
		int nframes;
		int goal;
		arst_n         = 1'b0;
		pixel.valid    = 1'b0;
		pixel.red_in   = '0;
		pixel.green_in = '0;
		pixel.blue_in  = '0;
		pixel.drain    = 1'b0;
		cfg.valid      = 1'b0;
		cfg.index      = '0;
		cfg.data       = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		src_idle_pct = 29;
		snk_idle_pct = 55;

		// a few pixels at the reset size, then a write restarts the frame
		send_pixels(3, 1'b0);
		settle();
		set_reg(REG_FRAME_WIDTH, 12'd3);
		set_reg(REG_FRAME_HEIGHT, 12'd3);

		// 3x3: corners, edges and the center; stray drain first, pixel as drain last
		send_word(8'hFF, 8'hFF, 8'hFF, 1'b1);
		for (i = 0; i < 9; i++)
			send_word((i % 2) ? 8'hFF : 8'h00, (i % 2) ? 8'h00 : 8'hFF,
				PIX_W'(i * 31), 1'b0);
		send_drains(3, 1'b0);
		send_word(8'h80, 8'h7F, 8'h01, 1'b0);
		settle();

		// zero width and height clamp to one
		set_reg(REG_FRAME_WIDTH, 12'd0);
		set_reg(REG_FRAME_HEIGHT, 12'd0);
		send_frame(1'b0);
		settle();

		// one column; an unknown register write mid-frame must not restart
		set_reg(REG_FRAME_WIDTH, 12'd1);
		set_reg(REG_FRAME_HEIGHT, 12'd3);
		send_pixels(1, 1'b0);
		settle();
		set_reg(REG_SPARE, 12'hFFF);
		send_pixels(2, 1'b0);
		send_drains(2, 1'b0);
		settle();

		// one row
		set_reg(REG_FRAME_WIDTH, 12'd3);
		set_reg(REG_FRAME_HEIGHT, 12'd1);
		send_frame(1'b0);
		settle();

		for (mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					src_idle_pct = 29;
					snk_idle_pct = 55;
				end
				1: begin
					src_idle_pct = 55;
					snk_idle_pct = 29;
				end
				default: begin
					src_idle_pct  = 0;
					snk_idle_pct  = 0;
					long_hold_req = 1'b1;
				end
			endcase
			goal = words_sent + MODE_ITEMS;
			while (words_sent < goal) begin
				pick_geometry();
				// abandoned frame: pixels short of any result, then restart
				if ($urandom_range(5) == 0) begin
					send_pixels($urandom_range(1, frame_cols()), 1'b1);
					settle();
					set_reg(REG_FRAME_HEIGHT, height_val);
				end
				nframes = $urandom_range(1, 2);
				for (i = 0; i < nframes; i++)
					send_frame(1'b1);
				settle();
			end
		end

		if (errors == 0)
			$display("tb_box_blur_3x3_rgb_unit: done, clean");
		else
			$display("tb_box_blur_3x3_rgb_unit: done, errors");
		$finish;
	end

endmodule

### filelist.f
hdl/bb3_pkg.sv
hdl/bb3_if.sv
hdl/bb3_ctrl.sv
hdl/bb3_line.sv
hdl/bb3_avg.sv
hdl/bb3_obuf.sv
hdl/box_blur_3x3_rgb_unit.sv
tb/bb3_blur_check.sv
tb/tb_box_blur_3x3_rgb_unit.sv
